@@ rtl/hsd_pkg.sv @@
// Shared types and constants for the Huffman stream decoder.
package hsd_pkg;

  localparam int SHAPE_W = 10;

  localparam logic [1:0] STAT_SYMBOL  = 2'd0;
  localparam logic [1:0] STAT_DONE    = 2'd1;
  localparam logic [1:0] STAT_DAMAGED = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SHAPE,
    PH_LEAVES,
    PH_DATA,
    PH_TAIL,
    PH_SKIP
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SHAPE,
    S_ADD1,
    S_ADD2,
    S_CLIMB_B,
    S_CLIMB_C,
    S_SHEND,
    S_FIN,
    S_FIN_CHK,
    S_LEAF_W,
    S_DATA,
    S_DATA_B,
    S_DATA_C,
    S_DEND,
    S_END,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

@@ rtl/hsd_out_stage.sv @@
// Output register that holds one result beat until the sink takes it.
module hsd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  hsd_pkg::result_t push_data,
  output logic             push_space,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,   // symbol
  output logic [1:0]       out_tuser,   // status
  output logic             out_tlast
);
  import hsd_pkg::*;

  logic    out_v_r, out_v_nxt;
  result_t out_d_r, out_d_nxt;

  assign push_space = !out_v_r || out_tready;

  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    if (push_space) begin
      out_v_nxt = push_valid;
      if (push_valid) begin
        out_d_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
    out_d_r <= out_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r.symbol;
  assign out_tuser  = out_d_r.status;
  assign out_tlast  = out_d_r.last;

endmodule

@@ rtl/hsd_ctrl.sv @@
// Byte sequencer: header parsing, tree building, leaf loading and bit-serial decoding.
module hsd_ctrl #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  output logic             push_valid,
  output hsd_pkg::result_t push_data,
  input  logic             push_space
);
  import hsd_pkg::*;

  localparam int NODES  = 2 * MAX_SYMBOLS;
  localparam int NODE_W = $clog2(NODES);
  localparam int LEAF_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int LCNT_W = $clog2(MAX_SYMBOLS + 1);

  // Tree stores, one write and one registered read port each.
  logic [NODE_W-1:0] left_mem  [NODES];
  logic [NODE_W-1:0] right_mem [NODES];
  logic [NODE_W-1:0] par_mem   [NODES];
  logic [1:0]        flags_mem [NODES];
  logic [7:0]        lval_mem  [NODES];
  logic [NODE_W-1:0] lord_mem  [MAX_SYMBOLS];

  logic [NODE_W-1:0] left_q, right_q, par_q, lord_q;
  logic [1:0]        flags_q;
  logic [7:0]        lval_q;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [3:0]        hdr_idx_r, hdr_idx_nxt;
  logic [15:0]       total_r, total_nxt;
  logic [63:0]       bits_r, bits_nxt;
  logic [SHAPE_W-1:0] shape_r, shape_nxt;
  logic [LCNT_W-1:0] leaf_r, leaf_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W-1:0] free_r, free_nxt;
  logic [NODE_W-1:0] at_r, at_nxt;
  logic [NODE_W-1:0] c_r, c_nxt;
  logic [NODE_W-1:0] fi_r, fi_nxt;
  logic [NODE_W-1:0] nxt_r, nxt_nxt;
  logic              add_left_r, add_left_nxt;
  logic [1:0]        root_flags_r, root_flags_nxt;
  logic              rd_zero_r;
  logic [7:0]        sh_r, sh_nxt;
  logic              last_r, last_nxt;
  logic [3:0]        bit_cnt_r, bit_cnt_nxt;
  result_t           pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;

  logic              emit_req;
  logic [7:0]        emit_sym;
  logic [1:0]        emit_stat;
  logic              can_emit;
  logic              stream_clear;

  logic [1:0]        flags_rd;
  logic [NODE_W-1:0] par_raddr, flags_raddr, lval_raddr, nxt_c;
  logic              flags_we;
  logic [NODE_W-1:0] flags_waddr;
  logic [1:0]        flags_wdata;
  logic              lr_we, par_we, lord_we, lval_we;

  logic [15:0]       hdr_total;
  logic [63:0]       hdr_bits;
  logic [3:0]        shape_nb, data_nb;

  assign can_emit  = !pend_v_r || push_space;
  assign in_tready = (state_r == S_IDLE);
  assign flags_rd  = rd_zero_r ? root_flags_r : flags_q;
  assign nxt_c     = sh_r[7] ? left_q : right_q;
  assign hdr_total = {total_r[7:0], sh_r};
  assign hdr_bits  = {bits_r[55:0], sh_r};
  assign shape_nb  = (shape_r < SHAPE_W'(8)) ? shape_r[3:0] : 4'd8;
  assign data_nb   = (bits_r < 64'd8) ? bits_r[3:0] : 4'd8;

  // Flag reads keep their address while a state waits for room to emit.
  always_comb begin
    par_raddr = par_q;
    if (state_r == S_SHAPE) begin
      par_raddr = cur_r;
    end
    flags_raddr = par_q;
    lval_raddr  = nxt_c;
    if (state_r == S_FIN || state_r == S_FIN_CHK) begin
      flags_raddr = fi_r;
    end else if (state_r == S_DATA_B || state_r == S_DATA_C) begin
      flags_raddr = nxt_c;
    end else if (state_r == S_CLIMB_C && c_r == '0) begin
      flags_raddr = c_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    total_nxt      = total_r;
    bits_nxt       = bits_r;
    shape_nxt      = shape_r;
    leaf_nxt       = leaf_r;
    cur_nxt        = cur_r;
    free_nxt       = free_r;
    at_nxt         = at_r;
    c_nxt          = c_r;
    fi_nxt         = fi_r;
    nxt_nxt        = nxt_r;
    add_left_nxt   = add_left_r;
    root_flags_nxt = root_flags_r;
    sh_nxt         = sh_r;
    last_nxt       = last_r;
    bit_cnt_nxt    = bit_cnt_r;
    emit_req       = 1'b0;
    emit_sym       = 8'd0;
    emit_stat      = STAT_DAMAGED;
    stream_clear   = 1'b0;
    flags_we       = 1'b0;
    flags_waddr    = at_r;
    flags_wdata    = 2'd0;
    lr_we          = 1'b0;
    par_we         = 1'b0;
    lord_we        = 1'b0;
    lval_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          sh_nxt      = in_tdata;
          last_nxt    = in_tlast;
          bit_cnt_nxt = 4'd0;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (phase_r)
          PH_HEADER: begin
            if (can_emit) begin
              hdr_idx_nxt = hdr_idx_r + 4'd1;
              state_nxt   = S_END;
              if (hdr_idx_r < 4'd2) begin
                total_nxt = hdr_total;
              end else begin
                bits_nxt = hdr_bits;
              end
              if (hdr_idx_r == 4'd1) begin
                if (hdr_total == 16'd0) begin
                  emit_req  = 1'b1;
                  emit_stat = STAT_DONE;
                  phase_nxt = PH_SKIP;
                end else if (hdr_total > 16'(MAX_SYMBOLS)) begin
                  emit_req  = 1'b1;
                  phase_nxt = PH_SKIP;
                end else if (hdr_total == 16'd1) begin
                  total_nxt = 16'd2;
                end
              end else if (hdr_idx_r >= 4'd9) begin
                if (hdr_bits[63]) begin
                  bits_nxt = 64'd0;
                end
                shape_nxt = {total_r[SHAPE_W-2:0], 1'b0} - SHAPE_W'(2);
                phase_nxt = PH_SHAPE;
              end
            end
          end
          PH_SHAPE:  state_nxt = S_SHAPE;
          PH_LEAVES: state_nxt = S_LEAF_W;
          PH_DATA:   state_nxt = S_DATA;
          PH_TAIL: begin
            if (can_emit) begin
              emit_req  = 1'b1;
              phase_nxt = PH_SKIP;
              state_nxt = S_END;
            end
          end
          default: state_nxt = S_END;
        endcase
      end
      S_SHAPE: begin
        if (bit_cnt_r == shape_nb) begin
          state_nxt = S_SHEND;
        end else if (sh_r[7]) begin
          at_nxt       = cur_r;
          add_left_nxt = 1'b1;
          state_nxt    = S_ADD1;
        end else if (cur_r == '0) begin
          // A climb from the root has nowhere to go.
          if (can_emit) begin
            emit_req  = 1'b1;
            phase_nxt = PH_SKIP;
            state_nxt = S_END;
          end
        end else begin
          state_nxt = S_CLIMB_B;
        end
      end
      S_CLIMB_B: begin
        c_nxt     = par_q;
        state_nxt = S_CLIMB_C;
      end
      S_CLIMB_C: begin
        if (c_r != '0 && flags_rd[1]) begin
          c_nxt = par_q;
        end else if (flags_rd[1]) begin
          if (can_emit) begin
            emit_req  = 1'b1;
            phase_nxt = PH_SKIP;
            state_nxt = S_END;
          end
        end else begin
          at_nxt       = c_r;
          add_left_nxt = 1'b0;
          state_nxt    = S_ADD1;
        end
      end
      S_ADD1: begin
        lr_we       = 1'b1;
        par_we      = 1'b1;
        flags_waddr = at_r;
        flags_wdata = add_left_r ? 2'b01 : 2'b11;
        if (at_r == '0) begin
          root_flags_nxt = flags_wdata;
        end else begin
          flags_we = 1'b1;
        end
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        flags_we    = 1'b1;
        flags_waddr = free_r;
        flags_wdata = 2'b00;
        cur_nxt     = free_r;
        free_nxt    = free_r + NODE_W'(1);
        sh_nxt      = {sh_r[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 4'd1;
        state_nxt   = S_SHAPE;
      end
      S_SHEND: begin
        shape_nxt = shape_r - SHAPE_W'(shape_nb);
        if (shape_r == SHAPE_W'(shape_nb)) begin
          fi_nxt    = '0;
          leaf_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_END;
        end
      end
      S_FIN: begin
        if (fi_r == free_r) begin
          if (16'(leaf_r) == total_r) begin
            phase_nxt = PH_LEAVES;
            leaf_nxt  = '0;
            cur_nxt   = '0;
            state_nxt = S_END;
          end else if (can_emit) begin
            emit_req  = 1'b1;
            phase_nxt = PH_SKIP;
            state_nxt = S_END;
          end
        end else begin
          state_nxt = S_FIN_CHK;
        end
      end
      S_FIN_CHK: begin
        if (flags_rd == 2'b01 || flags_rd == 2'b10 ||
            (flags_rd == 2'b00 && leaf_r == LCNT_W'(MAX_SYMBOLS))) begin
          if (can_emit) begin
            emit_req  = 1'b1;
            phase_nxt = PH_SKIP;
            state_nxt = S_END;
          end
        end else begin
          if (flags_rd == 2'b00) begin
            lord_we  = 1'b1;
            leaf_nxt = leaf_r + LCNT_W'(1);
          end
          fi_nxt    = fi_r + NODE_W'(1);
          state_nxt = S_FIN;
        end
      end
      S_LEAF_W: begin
        lval_we   = 1'b1;
        leaf_nxt  = leaf_r + LCNT_W'(1);
        if (16'(leaf_nxt) >= total_r) begin
          phase_nxt = (bits_r != 64'd0) ? PH_DATA : PH_TAIL;
        end
        state_nxt = S_END;
      end
      S_DATA: begin
        state_nxt = (bit_cnt_r == data_nb) ? S_DEND : S_DATA_B;
      end
      S_DATA_B: begin
        nxt_nxt   = nxt_c;
        state_nxt = S_DATA_C;
      end
      S_DATA_C: begin
        if (flags_rd == 2'b00) begin
          if (can_emit) begin
            emit_req    = 1'b1;
            emit_sym    = lval_q;
            emit_stat   = STAT_SYMBOL;
            cur_nxt     = '0;
            sh_nxt      = {sh_r[6:0], 1'b0};
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            state_nxt   = S_DATA;
          end
        end else begin
          cur_nxt     = nxt_r;
          sh_nxt      = {sh_r[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          state_nxt   = S_DATA;
        end
      end
      S_DEND: begin
        bits_nxt = bits_r - 64'(data_nb);
        if (bits_r == 64'(data_nb)) begin
          phase_nxt = PH_TAIL;
        end
        state_nxt = S_END;
      end
      S_END: begin
        if (!last_r) begin
          state_nxt = S_FLUSH;
        end else if (can_emit) begin
          if (phase_r == PH_TAIL) begin
            emit_req  = 1'b1;
            emit_stat = STAT_DONE;
          end else if (phase_r != PH_SKIP) begin
            emit_req = 1'b1;
          end
          stream_clear = 1'b1;
          state_nxt    = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r || push_space) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (stream_clear) begin
      phase_nxt      = PH_HEADER;
      hdr_idx_nxt    = 4'd0;
      total_nxt      = 16'd0;
      bits_nxt       = 64'd0;
      shape_nxt      = '0;
      leaf_nxt       = '0;
      cur_nxt        = '0;
      free_nxt       = NODE_W'(1);
      root_flags_nxt = 2'b00;
    end
  end

  // The newest result waits here until it is known whether it ends its byte.
  always_comb begin
    push_valid = 1'b0;
    push_data  = pend_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    if (emit_req) begin
      push_valid     = pend_v_r;
      push_data.last = 1'b0;
      pend_nxt       = '{symbol: emit_sym, status: emit_stat, last: 1'b0};
      pend_v_nxt     = 1'b1;
    end else if (state_r == S_FLUSH && pend_v_r && push_space) begin
      push_valid     = 1'b1;
      push_data.last = 1'b1;
      pend_v_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_HEADER;
      hdr_idx_r    <= 4'd0;
      total_r      <= 16'd0;
      bits_r       <= 64'd0;
      shape_r      <= '0;
      leaf_r       <= '0;
      cur_r        <= '0;
      free_r       <= NODE_W'(1);
      root_flags_r <= 2'b00;
      pend_v_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      total_r      <= total_nxt;
      bits_r       <= bits_nxt;
      shape_r      <= shape_nxt;
      leaf_r       <= leaf_nxt;
      cur_r        <= cur_nxt;
      free_r       <= free_nxt;
      root_flags_r <= root_flags_nxt;
      pend_v_r     <= pend_v_nxt;
    end
    at_r       <= at_nxt;
    c_r        <= c_nxt;
    fi_r       <= fi_nxt;
    nxt_r      <= nxt_nxt;
    add_left_r <= add_left_nxt;
    sh_r       <= sh_nxt;
    last_r     <= last_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    pend_r     <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (lr_we && add_left_r) begin
      left_mem[at_r] <= free_r;
    end
    if (lr_we && !add_left_r) begin
      right_mem[at_r] <= free_r;
    end
    if (par_we) begin
      par_mem[free_r] <= at_r;
    end
    if (flags_we) begin
      flags_mem[flags_waddr] <= flags_wdata;
    end
    if (lord_we) begin
      lord_mem[leaf_r[LEAF_W-1:0]] <= fi_r;
    end
    if (lval_we) begin
      lval_mem[lord_q] <= sh_r;
    end
    left_q    <= left_mem[cur_r];
    right_q   <= right_mem[cur_r];
    par_q     <= par_mem[par_raddr];
    flags_q   <= flags_mem[flags_raddr];
    rd_zero_r <= (flags_raddr == '0);
    lval_q    <= lval_mem[lval_raddr];
    lord_q    <= lord_mem[leaf_r[LEAF_W-1:0]];
  end

endmodule

@@ rtl/huffman_stream_decoder_unit.sv @@
// Top level of the Huffman stream decoder with a serialized tree.
//
//   channel  direction  tdata        tuser    tlast
//   in_      sink       in_byte      -        last_byte
//   out_     source     symbol       status   final_result
//
// A beat passes through accept, dispatch, end check and flush; a leaf beat adds a write state.
// Shape and data beats add states to close the byte, to add each left child or walk each data
// bit, to climb through each extra level and, after the last shape bit, to check every node.
// Reset is synchronous and active low; of the stores only the root flags register is reset.
// A stalled output holds the sequencer at its next result; input is taken between beats.
module huffman_stream_decoder_unit #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // symbol
  output logic [1:0] out_tuser,  // status
  output logic       out_tlast
);
  import hsd_pkg::*;

  logic    push_valid;
  result_t push_data;
  logic    push_space;

  hsd_ctrl #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_space (push_space)
  );

  hsd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_space (push_space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the Huffman stream decoder unit.

class hsd_scoreboard;
  hsd_pkg::result_t expected_q[$];
  int               mismatches;

  hsd_pkg::phase_t  phase;
  int               hdr_idx;
  logic [15:0]      sym_total;
  logic [63:0]      bits_left;
  int               shape_left;
  logic [8:0]       lchild[512];
  logic [8:0]       rchild[512];
  logic [8:0]       parent[512];
  logic [1:0]       flags[512];
  logic [7:0]       leaf_sym[512];
  logic [8:0]       leaf_idx[256];
  int               fill_idx;
  int               cur_node;
  int               free_node;
  hsd_pkg::result_t beat_res[$];

  function new();
    mismatches = 0;
    foreach (lchild[i]) begin
      lchild[i] = '0;
      rchild[i] = '0;
      parent[i] = '0;
      leaf_sym[i] = '0;
    end
    foreach (leaf_idx[i]) leaf_idx[i] = '0;
    clear_stream();
  endfunction

  function void clear_stream();
    phase = hsd_pkg::PH_HEADER;
    hdr_idx = 0;
    sym_total = '0;
    bits_left = '0;
    shape_left = 0;
    foreach (flags[i]) flags[i] = '0;
    fill_idx = 0;
    cur_node = 0;
    free_node = 1;
  endfunction

  function void push_res(logic [7:0] sym, logic [1:0] st);
    hsd_pkg::result_t r;
    r.symbol = sym;
    r.status = st;
    r.last = 1'b0;
    beat_res.push_back(r);
  endfunction

  function bit add_child(int at, bit go_left);
    int nn;
    nn = free_node;
    if (nn >= 512) return 1'b0;
    if (go_left) begin
      lchild[at] = nn[8:0];
      flags[at][0] = 1'b1;
    end else begin
      rchild[at] = nn[8:0];
      flags[at][1] = 1'b1;
    end
    parent[nn] = at[8:0];
    flags[nn] = '0;
    cur_node = nn;
    free_node = nn + 1;
    return 1'b1;
  endfunction

  function bit apply_shape_bit(bit b);
    int c;
    int steps;
    steps = 0;
    if (b) return add_child(cur_node, 1'b1);
    if (cur_node == 0) return 1'b0;
    c = int'(parent[cur_node]);
    // Climb to the first ancestor that still lacks a right child.
    while (c != 0 && flags[c][1] && steps < 512) begin
      c = int'(parent[c]);
      steps++;
    end
    if (flags[c][1]) return 1'b0;
    return add_child(c, 1'b0);
  endfunction

  function bit tree_ok();
    int leaves;
    int lim;
    leaves = 0;
    lim = (free_node < 512) ? free_node : 512;
    for (int i = 0; i < lim; i++) begin
      if (flags[i] == 2'd1 || flags[i] == 2'd2) return 1'b0;
      if (flags[i] == 2'd0) begin
        if (leaves >= 256) return 1'b0;
        leaf_idx[leaves] = i[8:0];
        leaves++;
      end
    end
    if (leaves != int'(sym_total)) return 1'b0;
    fill_idx = 0;
    cur_node = 0;
    return 1'b1;
  endfunction

  function void note_beat(logic [7:0] b, logic lst);
    int nb;
    int nxt;
    hsd_pkg::result_t r;
    beat_res.delete();
    case (phase)
      hsd_pkg::PH_HEADER: begin
        if (hdr_idx < 2) sym_total = {sym_total[7:0], b};
        else bits_left = {bits_left[55:0], b};
        if (hdr_idx == 1) begin
          if (sym_total == 16'd0) begin
            push_res(8'd0, hsd_pkg::STAT_DONE);
            phase = hsd_pkg::PH_SKIP;
          end else if (sym_total > 16'd256) begin
            push_res(8'd0, hsd_pkg::STAT_DAMAGED);
            phase = hsd_pkg::PH_SKIP;
          end else if (sym_total == 16'd1) begin
            sym_total = 16'd2;
          end
        end else if (hdr_idx >= 9) begin
          if (bits_left[63]) bits_left = '0;
          shape_left = 2 * int'(sym_total) - 2;
          phase = hsd_pkg::PH_SHAPE;
        end
        hdr_idx = (hdr_idx + 1) % 16;
      end
      hsd_pkg::PH_SHAPE: begin
        nb = (shape_left < 8) ? shape_left : 8;
        for (int k = 0; k < nb; k++) begin
          if (!apply_shape_bit(b[7-k])) begin
            push_res(8'd0, hsd_pkg::STAT_DAMAGED);
            phase = hsd_pkg::PH_SKIP;
            break;
          end
        end
        if (phase == hsd_pkg::PH_SHAPE) begin
          shape_left -= nb;
          if (shape_left == 0) begin
            if (tree_ok()) phase = hsd_pkg::PH_LEAVES;
            else begin
              push_res(8'd0, hsd_pkg::STAT_DAMAGED);
              phase = hsd_pkg::PH_SKIP;
            end
          end
        end
      end
      hsd_pkg::PH_LEAVES: begin
        leaf_sym[leaf_idx[fill_idx % 256]] = b;
        fill_idx = (fill_idx + 1) % 512;
        if (fill_idx >= int'(sym_total))
          phase = (bits_left != 64'd0) ? hsd_pkg::PH_DATA : hsd_pkg::PH_TAIL;
      end
      hsd_pkg::PH_DATA: begin
        nb = (bits_left < 64'd8) ? int'(bits_left) : 8;
        for (int k = 0; k < nb; k++) begin
          nxt = int'(b[7-k] ? lchild[cur_node] : rchild[cur_node]);
          if (flags[nxt] == 2'd0) begin
            push_res(leaf_sym[nxt], hsd_pkg::STAT_SYMBOL);
            cur_node = 0;
          end else begin
            cur_node = nxt;
          end
        end
        bits_left -= 64'(nb);
        if (bits_left == 64'd0) phase = hsd_pkg::PH_TAIL;
      end
      hsd_pkg::PH_TAIL: begin
        push_res(8'd0, hsd_pkg::STAT_DAMAGED);
        phase = hsd_pkg::PH_SKIP;
      end
      default: ;
    endcase
    if (lst) begin
      if (phase == hsd_pkg::PH_TAIL) push_res(8'd0, hsd_pkg::STAT_DONE);
      else if (phase != hsd_pkg::PH_SKIP) push_res(8'd0, hsd_pkg::STAT_DAMAGED);
      clear_stream();
    end
    if (beat_res.size() > 0) beat_res[beat_res.size()-1].last = 1'b1;
    foreach (beat_res[i]) begin
      r = beat_res[i];
      expected_q.push_back(r);
    end
  endfunction

  function void check_beat(logic [7:0] sym, logic [1:0] st, logic lst);
    hsd_pkg::result_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected beat: symbol %0h status %0d last %0b", sym, st, lst);
      return;
    end
    e = expected_q.pop_front();
    if (e.symbol !== sym || e.status !== st || e.last !== lst) begin
      mismatches++;
      if (mismatches <= 10)
        $display("beat mismatch: expected symbol %0h status %0d last %0b, got %0h %0d %0b",
                 e.symbol, e.status, e.last, sym, st, lst);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  import hsd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int BEAT_TARGET = 160;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  hsd_scoreboard sb;
  int            cycles;
  int            beats_sent;
  logic [7:0]    file_q[$];
  bit            shape_q[$];

  huffman_stream_decoder_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idling is switched off for one long stretch in the middle of the run.
  function automatic bit take_idle();
    if (cycles >= 800 && cycles < 1600) return 1'b0;
    return $urandom_range(0, 99) < 19;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !take_idle();
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_beat(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser, out_tlast);
  end

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) begin
      while (take_idle()) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= file_q[i];
      in_tlast <= (i == file_q.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      beats_sent++;
    end
  endtask

  // Preorder shape bits of a random full tree with the given number of leaves.
  function automatic void grow_shape(int leaves);
    int l;
    if (leaves <= 1) return;
    l = $urandom_range(1, leaves - 1);
    shape_q.push_back(1'b1);
    grow_shape(l);
    shape_q.push_back(1'b0);
    grow_shape(leaves - l);
  endfunction

  function automatic void build_file(int flavor);
    int          n;
    int          nbits;
    logic [63:0] data_len;
    logic [7:0]  acc;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
    nbits = $urandom_range(0, 40);
    data_len = 64'(nbits);
    if (flavor == 5) data_len = {1'b1, 31'($urandom()), 32'($urandom())};
    file_q.delete();
    shape_q.delete();
    file_q.push_back(n[15:8]);
    file_q.push_back(n[7:0]);
    for (int i = 7; i >= 0; i--) file_q.push_back(data_len[i*8 +: 8]);
    grow_shape((n == 1) ? 2 : n);
    // A chain of left children leaves every inner node half filled.
    if (flavor == 6) begin
      shape_q.delete();
      shape_q.push_back(1'b1);
      shape_q.push_back(1'b1);
      for (int i = 2; i < 2 * n - 2; i++) shape_q.push_back(1'b1);
    end
    acc = 8'($urandom());
    for (int i = 0; i < shape_q.size(); i++) begin
      acc[7 - i % 8] = shape_q[i];
      if (i % 8 == 7 || i == shape_q.size() - 1) begin
        file_q.push_back(acc);
        acc = 8'($urandom());
      end
    end
    for (int i = 0; i < ((n == 1) ? 2 : n); i++) file_q.push_back(8'($urandom()));
    if (flavor != 5)
      for (int i = 0; i < (nbits + 7) / 8; i++) file_q.push_back(8'($urandom()));
    case (flavor)
      1: file_q = file_q[0 : $urandom_range(0, file_q.size() - 2)];
      2: file_q.push_back(8'($urandom()));
      3: file_q[$urandom_range(0, file_q.size() - 1)] ^= 8'($urandom_range(1, 255));
      4: begin
        file_q.delete();
        repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom()));
      end
      default: ;
    endcase
  endfunction

  initial begin
    int pick;
    sb = new();
    beats_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty file, then bytes after its done status.
    file_q = '{8'h00, 8'h00, 8'hFF, 8'h5A};
    send_file();
    // Symbol count above the maximum.
    file_q = '{8'h01, 8'h01};
    send_file();
    // Climb from the root on the first shape bit.
    file_q = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00};
    send_file();
    // Two leaves, full byte of data bits, clean end.
    file_q = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08,
               8'h80, 8'hFF, 8'h00, 8'hA5};
    send_file();

    while (beats_sent < BEAT_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) build_file(0);
      else if (pick < 72) build_file(1);
      else if (pick < 79) build_file(2);
      else if (pick < 85) build_file(3);
      else if (pick < 90) build_file(4);
      else if (pick < 95) build_file(5);
      else build_file(6);
      send_file();
    end
    in_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/hsd_pkg.sv
rtl/hsd_out_stage.sv
rtl/hsd_ctrl.sv
rtl/huffman_stream_decoder_unit.sv
tb/tb_top.sv
